FILE: hdl/cfe_pkg.sv
package cfe_pkg;

  localparam int AngleBits = 16;
  localparam int Iter      = (AngleBits < 24) ? AngleBits : 24;
  localparam int CordW     = 36;
  localparam int GainQ16   = 107922;
  localparam int FaceW     = 3;
  localparam int PixW      = 12;
  localparam int EdgeW     = 13;
  localparam int SphW      = 14;
  localparam int OutColW   = 13;
  localparam int OutRowW   = 12;
  localparam int CoordW    = 14;
  localparam int MaxEdge   = 4096;
  localparam int MaxSphW   = 8192;
  localparam int EdgeReset = 512;
  localparam int SphReset  = 1024;

  localparam logic [FaceW-1:0] FACE_TOP    = 3'd4;
  localparam logic [FaceW-1:0] FACE_BOTTOM = 3'd5;

  localparam logic CFG_EDGE  = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  localparam logic [AngleBits-1:0] HalfTurn    = AngleBits'(1) << (AngleBits - 1);
  localparam logic [AngleBits-1:0] QuarterTurn = AngleBits'(1) << (AngleBits - 2);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    logic [FaceW-1:0]   face;
    logic signed [CordW-1:0] x1;
    logic signed [CordW-1:0] y1;
    logic signed [CordW-1:0] py2;
    color_t             color;
  } work_t;

  typedef struct packed {
    logic [OutColW-1:0] out_col;
    logic [OutRowW-1:0] out_row;
    color_t             color;
    logic               clamped;
  } res_t;

  function automatic logic [AngleBits-1:0] step_angle(input int i);
    logic [32:0] a;
    logic [32:0] t;
    case (i)
      0:  a = 33'd536870912;
      1:  a = 33'd316933406;
      2:  a = 33'd167458907;
      3:  a = 33'd85004756;
      4:  a = 33'd42667331;
      5:  a = 33'd21354465;
      6:  a = 33'd10679838;
      7:  a = 33'd5340245;
      8:  a = 33'd2670163;
      9:  a = 33'd1335087;
      10: a = 33'd667544;
      11: a = 33'd333772;
      12: a = 33'd166886;
      13: a = 33'd83443;
      14: a = 33'd41722;
      15: a = 33'd20861;
      16: a = 33'd10430;
      17: a = 33'd5215;
      18: a = 33'd2608;
      19: a = 33'd1304;
      20: a = 33'd652;
      21: a = 33'd326;
      22: a = 33'd163;
      23: a = 33'd81;
      default: a = 33'd0;
    endcase
    t = a + (33'd1 << (31 - AngleBits));
    return t[(32-AngleBits) +: AngleBits];
  endfunction

endpackage

FILE: hdl/cfe_fifo.sv
module cfe_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end
endmodule

FILE: hdl/cfe_front.sv
module cfe_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [cfe_pkg::EdgeW-1:0] edge_i,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [cfe_pkg::FaceW-1:0] face_i,
  input  logic [cfe_pkg::PixW-1:0]  col_i,
  input  logic [cfe_pkg::PixW-1:0]  row_i,
  input  cfe_pkg::color_t        color_i,
  output logic                   valid_o,
  output cfe_pkg::work_t         work_o,
  input  logic                   q_full_i
);
  import cfe_pkg::*;

  logic        v_q;
  work_t       work_q, work_d;
  logic        load;
  logic [PixW-1:0]         half;
  logic signed [CoordW-1:0] rowp, xc, yc;
  logic signed [CoordW:0]   ma;
  logic signed [CoordW+18:0] prod;
  logic        pole;

  assign full_o  = v_q && q_full_i;
  assign load    = !full_o;
  assign valid_o = v_q;
  assign work_o  = work_q;

  always_comb begin
    half = edge_i[EdgeW-1:1];
    rowp = (face_i == FACE_TOP) ? $signed(CoordW'(edge_i) - CoordW'(1) - CoordW'(row_i))
                                : $signed(CoordW'(row_i));
    xc   = $signed(CoordW'(col_i)) - $signed(CoordW'(half));
    yc   = $signed(CoordW'(half)) - rowp;
    pole = (face_i == FACE_TOP) || (face_i == FACE_BOTTOM);
    if (!pole) begin
      ma = (CoordW+1)'(yc);
    end else if (face_i == FACE_BOTTOM) begin
      ma = -$signed((CoordW+1)'(edge_i));
    end else begin
      ma = $signed((CoordW+1)'(edge_i));
    end
    prod = ma * $signed(19'(GainQ16));
    work_d.face  = face_i;
    work_d.color = color_i;
    work_d.py2   = CordW'(prod);
    if (pole) begin
      work_d.x1 = CordW'(xc) <<< 16;
      work_d.y1 = CordW'(yc) <<< 16;
    end else begin
      work_d.x1 = CordW'(half) <<< 16;
      work_d.y1 = CordW'(xc) <<< 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (load) begin
      v_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && push_i) begin
      work_q <= work_d;
    end
  end
endmodule

FILE: hdl/cfe_cordic.sv
module cfe_cordic #(
  parameter int TagW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [cfe_pkg::CordW-1:0] x_i,
  input  logic signed [cfe_pkg::CordW-1:0] y_i,
  input  logic [TagW-1:0]               tag_i,
  output logic                          valid_o,
  output logic [cfe_pkg::AngleBits-1:0] angle_o,
  output logic signed [cfe_pkg::CordW-1:0] mag_o,
  output logic [TagW-1:0]               tag_o
);
  import cfe_pkg::*;

  logic                    v_q    [Iter+2];
  logic signed [CordW-1:0] x_q    [Iter+1];
  logic signed [CordW-1:0] y_q    [Iter+1];
  logic [AngleBits-1:0]    z_q    [Iter+2];
  logic                    spec_q [Iter+1];
  logic [TagW-1:0]         tag_q  [Iter+2];
  logic signed [CordW-1:0] mag_q;

  logic signed [CordW-1:0] x0, y0;
  logic [AngleBits-1:0]    z0;
  logic                    s0;
  logic [48:0]             gprod;

  always_comb begin
    x0 = x_i;
    y0 = y_i;
    z0 = '0;
    s0 = 1'b0;
    if (y_i == '0) begin
      s0 = 1'b1;
      x0 = (x_i < 0) ? -x_i : x_i;
      z0 = (x_i < 0) ? HalfTurn : '0;
    end else if (x_i == '0) begin
      s0 = 1'b1;
      x0 = (y_i < 0) ? -y_i : y_i;
      z0 = (y_i > 0) ? QuarterTurn : -QuarterTurn;
    end else if (x_i < 0) begin
      x0 = -x_i;
      y0 = -y_i;
      z0 = HalfTurn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      spec_q[0] <= s0;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar g = 0; g < Iter; g++) begin : g_stage
    logic signed [CordW-1:0] dx, dy;
    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        spec_q[g+1] <= spec_q[g];
        tag_q[g+1]  <= tag_q[g];
        if (spec_q[g]) begin
          x_q[g+1] <= x_q[g];
          y_q[g+1] <= y_q[g];
          z_q[g+1] <= z_q[g];
        end else if (y_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + step_angle(g);
        end else begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - step_angle(g);
        end
      end
    end
  end

  assign gprod = 49'(x_q[Iter][31:0]) * 49'(GainQ16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[Iter+1] <= 1'b0;
    end else if (en_i) begin
      v_q[Iter+1] <= v_q[Iter];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[Iter+1]   <= z_q[Iter];
      tag_q[Iter+1] <= tag_q[Iter];
      mag_q         <= spec_q[Iter] ? $signed(CordW'(gprod[48:16])) : x_q[Iter];
    end
  end

  assign valid_o = v_q[Iter+1];
  assign angle_o = z_q[Iter+1];
  assign mag_o   = mag_q;
  assign tag_o   = tag_q[Iter+1];
endmodule

FILE: hdl/cfe_back.sv
module cfe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [cfe_pkg::SphW-1:0]  width_i,
  input  logic                      empty_i,
  input  cfe_pkg::work_t            work_i,
  output logic                      pop_o,
  output logic                      valid_o,
  output cfe_pkg::res_t             res_o,
  input  logic                      out_full_i
);
  import cfe_pkg::*;

  typedef struct packed {
    logic [FaceW-1:0]        face;
    logic signed [CordW-1:0] py2;
    color_t                  color;
  } tag1_t;

  typedef struct packed {
    logic [AngleBits-1:0] theta;
    color_t               color;
  } tag2_t;

  logic en;
  logic c1_v, c2_v;
  logic [AngleBits-1:0] a1, a2;
  logic signed [CordW-1:0] m1, m2;
  tag1_t t1_in, t1;
  tag2_t t2;

  logic mid_v_q;
  logic signed [CordW-1:0] mx_q, my_q;
  tag2_t mt_q;
  logic [AngleBits-1:0] qyaw;

  logic f1_v_q, f2_v_q;
  logic [AngleBits+SphW-1:0] thw_q;
  logic signed [AngleBits+SphW-1:0] ph_q;
  color_t f1_c_q;
  res_t res_q, res_d;

  logic [SphW-2:0] h;
  logic signed [31:0] num;
  logic signed [16:0] yq;

  assign en    = !(f2_v_q && out_full_i);
  assign pop_o = en && !empty_i;
  assign h     = width_i[SphW-1:1];

  assign t1_in.face  = work_i.face;
  assign t1_in.py2   = work_i.py2;
  assign t1_in.color = work_i.color;

  cfe_cordic #(.TagW($bits(tag1_t))) u_cordic1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(!empty_i),
    .x_i(work_i.x1), .y_i(work_i.y1), .tag_i(t1_in),
    .valid_o(c1_v), .angle_o(a1), .mag_o(m1), .tag_o(t1)
  );

  assign qyaw = AngleBits'(t1.face[1:0]) << (AngleBits - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
    end else if (en) begin
      mid_v_q <= c1_v;
      f1_v_q  <= c2_v;
      f2_v_q  <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mt_q.color <= t1.color;
      my_q       <= t1.py2;
      if (t1.face == FACE_TOP || t1.face == FACE_BOTTOM) begin
        mt_q.theta <= a1;
        mx_q       <= m1 <<< 1;
      end else begin
        mt_q.theta <= qyaw - a1;
        mx_q       <= m1;
      end
    end
  end

  cfe_cordic #(.TagW($bits(tag2_t))) u_cordic2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(mid_v_q),
    .x_i(mx_q), .y_i(my_q), .tag_i(mt_q),
    .valid_o(c2_v), .angle_o(a2), .mag_o(m2), .tag_o(t2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      thw_q  <= (AngleBits+SphW)'(t2.theta) * (AngleBits+SphW)'(width_i);
      ph_q   <= (AngleBits+SphW)'($signed(a2)) * $signed((AngleBits+SphW)'(h));
      f1_c_q <= t2.color;
    end
  end

  always_comb begin
    num = $signed(32'(h[SphW-2:1]) << AngleBits) - (32'(ph_q) <<< 1);
    if (num >= 0) begin
      yq = 17'(num >>> AngleBits);
    end else begin
      yq = -$signed(17'((-num) >>> AngleBits));
    end
    res_d.out_col = thw_q[AngleBits +: OutColW];
    res_d.color   = f1_c_q;
    res_d.clamped = 1'b0;
    res_d.out_row = OutRowW'(yq);
    if (yq < 0) begin
      res_d.out_row = '0;
      res_d.clamped = 1'b1;
    end else if (yq > $signed(17'(h)) - 17'sd1) begin
      res_d.out_row = OutRowW'(h - 1'b1);
      res_d.clamped = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign valid_o = f2_v_q;
  assign res_o   = res_q;
endmodule

FILE: hdl/cube_face_to_equirect_mapper.sv
// Forward maps one cube-face pixel per beat to its equirectangular position and
// passes the color through. A new pixel is accepted every clock while results are
// drained; a result passes through the front stage, the middle queue, two 16-stage
// pipelined CORDIC vectoring units in series (each with an entry and an exit stage),
// the stage between them, two scaling stages and the output queue. Rows outside the
// image are clamped and flagged. Write face_edge and sphere_width only while no
// pixels are in flight; writes saturate to the legal range.
module cube_face_to_equirect_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cfe_pkg::SphW-1:0]      cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [cfe_pkg::FaceW-1:0]     face_i,
  input  logic [cfe_pkg::PixW-1:0]      col_i,
  input  logic [cfe_pkg::PixW-1:0]      row_i,
  input  logic [7:0]                    blue_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    red_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [cfe_pkg::OutColW-1:0]   out_col_o,
  output logic [cfe_pkg::OutRowW-1:0]   out_row_o,
  output logic [7:0]                    blue_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    red_out_o,
  output logic                          clamped_o
);
  import cfe_pkg::*;

  logic [EdgeW-1:0] edge_q, edge_d;
  logic [SphW-1:0]  width_q, width_d;
  logic [EdgeW-1:0] ev;

  color_t cin;
  logic   f_v, mq_full, mq_empty, b_pop, b_v, oq_full;
  work_t  f_w, b_w;
  res_t   b_r, o_r;

  assign ev = cfg_data_i[EdgeW-1:0];

  always_comb begin
    edge_d  = edge_q;
    width_d = width_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_EDGE: begin
          if (ev < EdgeW'(2)) edge_d = EdgeW'(2);
          else if (ev > EdgeW'(MaxEdge)) edge_d = EdgeW'(MaxEdge);
          else edge_d = ev;
        end
        CFG_WIDTH: begin
          if (cfg_data_i < SphW'(2)) width_d = SphW'(2);
          else if (cfg_data_i > SphW'(MaxSphW)) width_d = SphW'(MaxSphW);
          else width_d = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= EdgeW'(EdgeReset);
      width_q <= SphW'(SphReset);
    end else begin
      edge_q  <= edge_d;
      width_q <= width_d;
    end
  end

  assign cin.blue  = blue_in_i;
  assign cin.green = green_in_i;
  assign cin.red   = red_in_i;

  cfe_front u_front (
    .clk_i, .rst_ni, .edge_i(edge_q),
    .push_i(push), .full_o(full),
    .face_i, .col_i, .row_i, .color_i(cin),
    .valid_o(f_v), .work_o(f_w), .q_full_i(mq_full)
  );

  cfe_fifo #(.Width($bits(work_t)), .Depth(2)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i(f_v), .wdata_i(f_w), .full_o(mq_full),
    .pop_i(b_pop), .rdata_o(b_w), .empty_o(mq_empty)
  );

  cfe_back u_back (
    .clk_i, .rst_ni, .width_i(width_q),
    .empty_i(mq_empty), .work_i(b_w), .pop_o(b_pop),
    .valid_o(b_v), .res_o(b_r), .out_full_i(oq_full)
  );

  cfe_fifo #(.Width($bits(res_t)), .Depth(2)) u_out_q (
    .clk_i, .rst_ni,
    .push_i(b_v), .wdata_i(b_r), .full_o(oq_full),
    .pop_i(pop), .rdata_o(o_r), .empty_o(empty)
  );

  assign out_col_o   = o_r.out_col;
  assign out_row_o   = o_r.out_row;
  assign blue_out_o  = o_r.color.blue;
  assign green_out_o = o_r.color.green;
  assign red_out_o   = o_r.color.red;
  assign clamped_o   = o_r.clamped;
endmodule
